// ===== rtl/core/aes128_pkg.sv =====
// ---------------------------------------------------------------------------
// aes128_pkg
// shared types, constants and byte functions for the aes-128 encryptor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_beat_t;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    gf_dbl = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block sits at bits 127-8i
  function automatic logic [7:0] blk_byte(input block_t s, input int i);
    blk_byte = s[127-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = SBOX[blk_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = blk_byte(s, 4*c);
      a1 = blk_byte(s, 4*c+1);
      a2 = blk_byte(s, 4*c+2);
      a3 = blk_byte(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127-32*c -: 8]  = a0 ^ al ^ gf_dbl(a0 ^ a1);
      t[119-32*c -: 8]  = a1 ^ al ^ gf_dbl(a1 ^ a2);
      t[111-32*c -: 8]  = a2 ^ al ^ gf_dbl(a2 ^ a3);
      t[103-32*c -: 8]  = a3 ^ al ^ gf_dbl(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    t  = t ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== rtl/core/aes128_key_sched.sv =====
// ---------------------------------------------------------------------------
// aes128_key_sched
// holds the cipher key and an eleven-entry round key register file,
// expanded one round per stage from a chain of key registers
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes128_key_sched
  import aes128_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_idx,
  input  logic [63:0]          cfg_data,
  output block_t               rkey [NumRounds+1]
);

  block_t rk_r [NumRounds+1];
  block_t rk_nxt [NumRounds+1];

  // rk_r[0] is the key itself, each later entry is registered from the next key
  // of its predecessor in the cycle after; the chain settles entry by entry after a write
  always_comb begin
    rk_nxt[0] = rk_r[0];
    if (cfg_we) begin
      case (cfg_idx)
        REG_KEY_HIGH: rk_nxt[0] = {cfg_data, rk_r[0][63:0]};
        REG_KEY_LOW:  rk_nxt[0] = {rk_r[0][127:64], cfg_data};
        default:      rk_nxt[0] = rk_r[0];
      endcase
    end
    for (int r = 1; r <= NumRounds; r++) begin
      rk_nxt[r] = next_key(rk_r[r-1], RCON[r-1]);
    end
  end

  // reset walks the all-zero key through the chain like any other key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r[0] <= '0;
    end else begin
      rk_r[0] <= rk_nxt[0];
    end
    for (int r = 1; r <= NumRounds; r++) begin
      rk_r[r] <= rk_nxt[r];
    end
  end

  assign rkey = rk_r;

endmodule

// ===== rtl/core/aes128_round.sv =====
// ---------------------------------------------------------------------------
// aes128_round
// one registered cipher round with its own valid bit and stall hold
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes128_round
  import aes128_pkg::*;
#(
  parameter bit LAST = 1'b0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   vld_i,
  input  block_t dat_i,
  input  block_t rkey,
  output logic   vld_o,
  output block_t dat_o
);

  logic   vld_r, vld_nxt;
  block_t dat_r, dat_nxt;
  block_t ss;

  always_comb begin
    ss      = sub_shift(dat_i);
    vld_nxt = adv ? vld_i : vld_r;
    dat_nxt = dat_r;
    if (adv) begin
      dat_nxt = (LAST ? ss : mix_cols(ss)) ^ rkey;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    dat_r <= dat_nxt;
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

// ===== rtl/core/aes128_block_encrypt.sv =====
// ---------------------------------------------------------------------------
// aes128_block_encrypt
// aes-128 ecb encryptor: initial key add stage and ten round stages; while
// out_stall is low it takes one block per clock
// ---------------------------------------------------------------------------
//  channel  direction  handshake            beat
//  in_      input      in_valid / in_stall  in_beat_t (plain_high, plain_low)
//  out_     output     out_valid/out_stall  out_beat_t (cipher_high, cipher_low)
//  cfg_     input      cfg_we               cfg_idx, cfg_data (key halves)
//
//  beats pass the key add and ten round registers; with out_stall low the whole
//  pipeline advances, one beat per clock, else only stages before a bubble do
//  in_stall follows out_stall when the pipe is full: nothing is dropped
//  reset clears the valid bits; the zero-key schedule settles entry by entry
//  after a key write, round keys settle entry by entry, each a register later
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes128_block_encrypt
  import aes128_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_beat_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_beat_t          out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [63:0]        cfg_data
);

  block_t rkey [NumRounds+1];
  logic   vld [NumRounds+1];
  block_t dat [NumRounds+1];
  logic   adv [NumRounds+1];
  logic   v0_r, v0_nxt;
  block_t d0_r, d0_nxt;

  aes128_key_sched u_ks (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .rkey
  );

  // stage i may load when it is empty or stage i+1 takes its beat
  always_comb begin
    adv[NumRounds] = !vld[NumRounds] || !out_stall;
    for (int i = NumRounds - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_comb begin
    v0_nxt = adv[0] ? in_valid : v0_r;
    d0_nxt = d0_r;
    if (adv[0]) begin
      d0_nxt = {in_data.plain_high, in_data.plain_low} ^ rkey[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
    d0_r <= d0_nxt;
  end

  assign vld[0] = v0_r;
  assign dat[0] = d0_r;

  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes128_round #(.LAST(g == NumRounds)) u_rnd (
      .clk, .rst_n,
      .adv   (adv[g]),
      .vld_i (vld[g-1]),
      .dat_i (dat[g-1]),
      .rkey  (rkey[g]),
      .vld_o (vld[g]),
      .dat_o (dat[g])
    );
  end

  assign out_valid            = vld[NumRounds];
  assign out_data.cipher_high = dat[NumRounds][127:64];
  assign out_data.cipher_low  = dat[NumRounds][63:0];

endmodule
